### hdl/dti_pkg.sv
// Package: shared types and constants for the decimal token to int32 converter.
package dti_pkg;

   localparam int MAX_TOKEN_BYTES_DEF = 31;

   localparam logic [35:0] MAG_CAP    = 36'd2147483649;
   localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

   localparam logic [1:0] KIND_PRIMITIVE = 2'd0;
   localparam logic [1:0] KIND_STRING    = 2'd1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               error;
   } result_type;

endpackage

### hdl/dti_if.sv
// Interfaces: request (token byte) and response (parsed value) channels.
interface dti_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       has_char;
   logic       last;
   logic [1:0] token_kind;

   modport source (output valid, char_byte, has_char, last, token_kind, input ready);
   modport sink   (input valid, char_byte, has_char, last, token_kind, output ready);
endinterface

interface dti_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               error;

   modport source (output valid, value, error, input ready);
   modport sink   (input valid, value, error, output ready);
endinterface

### hdl/dti_parser.sv
// Parser: per-token parse state, one byte per step, and the result of the closing byte.
module dti_parser #(
   parameter int MAX_TOKEN_BYTES = dti_pkg::MAX_TOKEN_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_byte,
   input  logic                has_char,
   input  logic                last,
   input  logic [1:0]          token_kind,
   output dti_pkg::result_type result
);

   localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 1);

   dti_pkg::phase_type phase_ff, phase_in;
   logic               negative_ff, negative_in;
   logic [31:0]        magnitude_ff, magnitude_in;
   logic               overflowed_ff, overflowed_in;
   logic               syntax_bad_ff, syntax_bad_in;
   logic               terminated_ff, terminated_in;
   logic [CNT_W-1:0]   byte_count_ff, byte_count_in;
   logic               too_long_ff, too_long_in;

   logic               is_digit;
   logic               is_space;
   logic [35:0]        product;
   logic               err;

   assign is_digit = (char_byte >= dti_pkg::CHAR_ZERO) && (char_byte <= dti_pkg::CHAR_NINE);
   assign is_space = (char_byte == dti_pkg::CHAR_SPACE)
                     || ((char_byte >= dti_pkg::CHAR_TAB) && (char_byte <= dti_pkg::CHAR_CR));
   assign product  = ({4'b0, magnitude_ff} << 3) + ({4'b0, magnitude_ff} << 1)
                     + {32'b0, char_byte[3:0] - dti_pkg::CHAR_ZERO[3:0]};

   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      overflowed_in = overflowed_ff;
      syntax_bad_in = syntax_bad_ff;
      terminated_in = terminated_ff;
      byte_count_in = byte_count_ff;
      too_long_in   = too_long_ff;
      if (has_char) begin
         if (byte_count_ff >= CNT_W'(MAX_TOKEN_BYTES)) begin
            too_long_in = 1'b1;
         end else begin
            byte_count_in = byte_count_ff + CNT_W'(1);
         end
         if (!terminated_ff) begin
            if (char_byte == dti_pkg::CHAR_NUL) begin
               terminated_in = 1'b1;
            end else if (is_digit) begin
               if (!(phase_ff == dti_pkg::PH_DIGITS && syntax_bad_ff)) begin
                  phase_in = dti_pkg::PH_DIGITS;
                  if (product >= dti_pkg::MAG_CAP) begin
                     magnitude_in  = dti_pkg::MAG_CAP[31:0];
                     overflowed_in = 1'b1;
                  end else begin
                     magnitude_in = product[31:0];
                  end
               end
            end else if (phase_ff == dti_pkg::PH_SPACE && is_space) begin
               phase_in = dti_pkg::PH_SPACE;
            end else if (phase_ff == dti_pkg::PH_SPACE
                         && (char_byte == dti_pkg::CHAR_PLUS
                             || char_byte == dti_pkg::CHAR_MINUS)) begin
               negative_in = (char_byte == dti_pkg::CHAR_MINUS);
               phase_in    = dti_pkg::PH_SIGN;
            end else begin
               syntax_bad_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      err = (token_kind != dti_pkg::KIND_PRIMITIVE && token_kind != dti_pkg::KIND_STRING)
            || too_long_in || syntax_bad_in || overflowed_in
            || (phase_in != dti_pkg::PH_DIGITS)
            || (negative_in ? (magnitude_in > dti_pkg::NEG_LIMIT)
                            : (magnitude_in > dti_pkg::POS_LIMIT));
      result.error = err;
      if (err) begin
         result.value = '1;
      end else if (negative_in) begin
         result.value = 32'sd0 - $signed(magnitude_in);
      end else begin
         result.value = $signed(magnitude_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff      <= dti_pkg::PH_SPACE;
         negative_ff   <= 1'b0;
         magnitude_ff  <= '0;
         overflowed_ff <= 1'b0;
         syntax_bad_ff <= 1'b0;
         terminated_ff <= 1'b0;
         byte_count_ff <= '0;
         too_long_ff   <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
         overflowed_ff <= overflowed_in;
         syntax_bad_ff <= syntax_bad_in;
         terminated_ff <= terminated_in;
         byte_count_ff <= byte_count_in;
         too_long_ff   <= too_long_in;
      end
   end

endmodule

### hdl/decimal_token_to_int32_core.sv
// Top level: decimal token to signed 32-bit integer converter.
//
// req_bus carries the bytes of one token, one byte per transaction, with
// has_char, last and token_kind. rsp_bus carries one transaction per token
// (value, error), issued for the transaction marked last; other request
// transactions give no response. On error value is all ones.
//
// Throughput: one request transaction per cycle unless rsp_bus stalls, set by
// the single multiply-by-ten-and-add step of the parser. The last byte passes
// through the input register, then the result register that drives rsp_bus.
// When rsp_bus stalls, the result register holds and the input register
// takes one more byte; req_bus.ready drops only while both are full.
//
// Reset (synchronous, active high) empties both registers and returns the
// parse state to its start; a partly received token is dropped.
module decimal_token_to_int32_core #(
   parameter int MAX_TOKEN_BYTES = dti_pkg::MAX_TOKEN_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   dti_req_if.sink   req_bus,
   dti_rsp_if.source rsp_bus
);

   logic                in_valid_ff;
   logic [7:0]          char_byte_ff;
   logic                has_char_ff;
   logic                last_ff;
   logic [1:0]          token_kind_ff;
   logic                step;
   logic                out_valid_ff;
   dti_pkg::result_type result;
   dti_pkg::result_type result_ff;

   assign step          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         char_byte_ff  <= req_bus.char_byte;
         has_char_ff   <= req_bus.has_char;
         last_ff       <= req_bus.last;
         token_kind_ff <= req_bus.token_kind;
      end
   end

   dti_parser #(
      .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_byte (char_byte_ff),
      .has_char  (has_char_ff),
      .last      (last_ff),
      .token_kind(token_kind_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_bus.ready) begin
         out_valid_ff <= step && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && last_ff) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.value = result_ff.value;
   assign rsp_bus.error = result_ff.error;

endmodule

### hdl/dti_checker.sv
// Checker: port-level assertions for the converter, bound to the top level.
module dti_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value,
   input logic               rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_error))
      else $error("response changed while stalled");

   a_error_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == -32'sd1)
      else $error("error response without all-ones value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a response stall");

endmodule

bind decimal_token_to_int32_core dti_checker u_dti_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_value(rsp_bus.value),
   .rsp_error(rsp_bus.error)
);
